[rtl/core/pbalc_pkg.sv]
// Shared types and constants for the partition bump allocator.
package pbalc_pkg;

    // Widths fixed by the request and result fields.
    localparam int unsigned PID_W    = 64;
    localparam int unsigned STREAM_W = 32;
    localparam int unsigned UNITS_W  = 7;
    localparam int unsigned MASK_W   = 64;
    localparam int unsigned LIVE_W   = 7;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned OP_W     = 2;

    // Slot index and live count widths cover the largest supported table (4096 entries).
    localparam int unsigned IDX_W = 12;
    localparam int unsigned CNT_W = 13;

    localparam logic [LIVE_W-1:0] LIVE_MAX = 7'd127;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_STATS   = 2'd2,
        OP_INVALID = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_BAD_OP   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } t_state;

    // Search token that walks down the row of table cells.
    typedef struct packed {
        logic              valid;
        logic              hit;
        logic [IDX_W-1:0]  hit_idx;
        logic [MASK_W-1:0] hit_mask;
        logic              free;
        logic [IDX_W-1:0]  free_idx;
        logic [CNT_W-1:0]  count;
    } t_token;

    // Table update broadcast to every cell at the end of a request.
    typedef struct packed {
        logic                en;
        logic                set;
        logic [IDX_W-1:0]    idx;
        logic [PID_W-1:0]    pid;
        logic [STREAM_W-1:0] stream;
        logic [MASK_W-1:0]   mask;
    } t_write;

endpackage

[rtl/core/pbalc_cell.sv]
// One table slot of the allocator with its stage of the search token chain.
module pbalc_cell
    import pbalc_pkg::*;
#(
    parameter int unsigned CELL_IDX = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [PID_W-1:0]    i_pid,
    input  logic [STREAM_W-1:0] i_stream,
    input  t_token              i_tok,
    input  t_write              i_wr,
    output t_token              o_tok
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic                r_live;
    logic [PID_W-1:0]    r_pid;
    logic [STREAM_W-1:0] r_stream;
    logic [MASK_W-1:0]   r_mask;
    t_token              r_tok;
    t_token              n_tok;
    logic                w_match;

    assign w_match = r_live && (r_pid == i_pid) && (r_stream == i_stream);

    // The earliest matching slot and the earliest free slot win.
    always_comb begin
        n_tok = i_tok;
        if (!i_tok.hit && w_match) begin
            n_tok.hit      = 1'b1;
            n_tok.hit_idx  = MY_IDX;
            n_tok.hit_mask = r_mask;
        end
        if (!i_tok.free && !r_live) begin
            n_tok.free     = 1'b1;
            n_tok.free_idx = MY_IDX;
        end
        n_tok.count = i_tok.count + CNT_W'(r_live);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= i_tok.valid;
        end
        r_tok.hit      <= n_tok.hit;
        r_tok.hit_idx  <= n_tok.hit_idx;
        r_tok.hit_mask <= n_tok.hit_mask;
        r_tok.free     <= n_tok.free;
        r_tok.free_idx <= n_tok.free_idx;
        r_tok.count    <= n_tok.count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= 1'b0;
        end else if (i_wr.en && (i_wr.idx == MY_IDX)) begin
            r_live <= i_wr.set;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en && i_wr.set && (i_wr.idx == MY_IDX)) begin
            r_pid    <= i_wr.pid;
            r_stream <= i_wr.stream;
            r_mask   <= i_wr.mask;
        end
    end

    assign o_tok = r_tok;

endmodule

[rtl/core/partition_bump_allocator.sv]
// Top level of the partition bump allocator: request control, bump cursor and cell row.
// Each request is held while a search token walks the row of TABLE_ENTRIES table cells,
// one cell per clock, gathering the first slot holding the key, its mask, the first free
// slot and the live count. The finished token is captured in the next cycle, and then the
// commit state applies the table update and loads the result register. The next request
// is taken from the cycle after the result has been loaded, so a request is not taken
// before the one ahead of it is through. A result that has not yet been taken holds back
// the update of the one behind it. The unit count register may be written at any time the
// block is idle.
module partition_bump_allocator
    import pbalc_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration: unit_count
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [UNITS_W-1:0]   i_cfg_data,
    // Requests
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [103:0]         i_s_tdata,  // client_pid, client_stream, units_wanted, pad
    input  logic [OP_W-1:0]      i_s_tuser,  // op
    // Results
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [71:0]          o_m_tdata,  // disabled_units, live_entries, pad
    output logic [2:0]           o_m_tuser   // status, granted
);

    t_state r_state;
    t_state n_state;

    logic [OP_W-1:0]     r_op;
    logic [PID_W-1:0]    r_pid;
    logic [STREAM_W-1:0] r_stream;
    logic [UNITS_W-1:0]  r_want;
    logic                r_start;
    logic [UNITS_W-1:0]  r_unit_count;
    logic [UNITS_W-1:0]  r_next_unit;
    t_token              r_fin;

    logic                r_m_valid;
    logic [STATUS_W-1:0] r_m_status;
    logic                r_m_has;
    logic [MASK_W-1:0]   r_m_mask;
    logic [LIVE_W-1:0]   r_m_live;

    logic w_accept;
    logic w_commit;
    logic w_tok_done;

    t_token tok [TABLE_ENTRIES+1];
    t_write w_wr;

    logic [MASK_W-1:0]   w_valid_mask;
    logic [MASK_W-1:0]   w_grant;
    logic [UNITS_W:0]    w_sum;
    logic                w_fit;
    logic [CNT_W-1:0]    w_live_cnt;
    logic [LIVE_W-1:0]   w_live_sat;
    logic [STATUS_W-1:0] w_status;
    logic                w_has;
    logic [MASK_W-1:0]   w_mask;
    logic [LIVE_W-1:0]   w_live;
    logic                w_bump;

    assign o_cfg_ready = 1'b1;

    // Search token enters the row the cycle after the request transfer.
    always_comb begin
        tok[0]       = '0;
        tok[0].valid = r_start;
    end

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        pbalc_cell #(
            .CELL_IDX(g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_pid   (r_pid),
            .i_stream(r_stream),
            .i_tok   (tok[g]),
            .i_wr    (w_wr),
            .o_tok   (tok[g+1])
        );
    end

    assign w_tok_done = tok[TABLE_ENTRIES].valid;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (w_tok_done) n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (!r_m_valid || i_m_tready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_s_tready = 1'b0;
        w_commit   = 1'b0;
        case (r_state)
            S_IDLE:   o_s_tready = 1'b1;
            S_SCAN:   ;
            S_COMMIT: w_commit = !r_m_valid || i_m_tready;
            default:  ;
        endcase
    end

    assign w_accept = i_s_tvalid && o_s_tready;

    // Result of the finished search.
    always_comb begin
        if (r_unit_count >= UNITS_W'(MASK_W)) begin
            w_valid_mask = '1;
        end else begin
            w_valid_mask = (MASK_W'(1) << r_unit_count[5:0]) - MASK_W'(1);
        end

        if (r_want >= UNITS_W'(MASK_W)) begin
            w_grant = '1;
        end else if (r_next_unit >= UNITS_W'(MASK_W)) begin
            w_grant = '0;
        end else begin
            w_grant = ((MASK_W'(1) << r_want[5:0]) - MASK_W'(1)) << r_next_unit[5:0];
        end
        w_grant = w_grant & w_valid_mask;

        w_sum = {1'b0, r_next_unit} + {1'b0, r_want};
        w_fit = (r_want <= r_unit_count) && (w_sum <= {1'b0, r_unit_count});

        // A free that found its key removes one live entry.
        w_live_cnt = r_fin.count - CNT_W'((r_op == OP_FREE) && r_fin.hit);
        if (w_live_cnt > CNT_W'(LIVE_MAX)) begin
            w_live_sat = LIVE_MAX;
        end else begin
            w_live_sat = w_live_cnt[LIVE_W-1:0];
        end

        w_status = ST_OK;
        w_has    = 1'b0;
        w_mask   = '0;
        w_live   = '0;
        w_bump   = 1'b0;
        w_wr     = '0;
        w_wr.pid    = r_pid;
        w_wr.stream = r_stream;
        w_wr.mask   = (~w_grant) & w_valid_mask;

        case (r_op)
            OP_ALLOC: begin
                if (r_want != '0) begin
                    if (r_fin.hit) begin
                        w_has  = 1'b1;
                        w_mask = r_fin.hit_mask;
                    end else if (w_fit) begin
                        if (!r_fin.free) begin
                            w_status = ST_NO_SPACE;
                        end else begin
                            w_has     = 1'b1;
                            w_mask    = (~w_grant) & w_valid_mask;
                            w_bump    = w_commit;
                            w_wr.en   = w_commit;
                            w_wr.set  = 1'b1;
                            w_wr.idx  = r_fin.free_idx;
                        end
                    end
                end
            end
            OP_FREE: begin
                w_live    = w_live_sat;
                w_wr.en   = w_commit && r_fin.hit;
                w_wr.set  = 1'b0;
                w_wr.idx  = r_fin.hit_idx;
            end
            OP_STATS: begin
                w_live = w_live_sat;
            end
            default: begin
                w_status = ST_BAD_OP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_start      <= 1'b0;
            r_unit_count <= UNITS_W'(64);
            r_next_unit  <= '0;
            r_m_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= w_accept;
            if (i_cfg_valid) begin
                r_unit_count <= i_cfg_data;
            end
            if (w_bump) begin
                r_next_unit <= w_sum[UNITS_W-1:0];
            end
            if (w_commit) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= i_s_tuser;
            r_pid    <= i_s_tdata[63:0];
            r_stream <= i_s_tdata[95:64];
            r_want   <= i_s_tdata[102:96];
        end
        if (r_state == S_SCAN && w_tok_done) begin
            r_fin <= tok[TABLE_ENTRIES];
        end
        if (w_commit) begin
            r_m_status <= w_status;
            r_m_has    <= w_has;
            r_m_mask   <= w_mask;
            r_m_live   <= w_live;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {1'b0, r_m_live, r_m_mask};
    assign o_m_tuser  = {r_m_has, r_m_status};

endmodule

[bench/allocator_checker.sv]
`timescale 1ns / 1ps
// Checker that predicts every allocator result from the observed transfers and compares it.
module allocator_checker
    import pbalc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [UNITS_W-1:0] i_cfg_data,
    input  logic               i_s_tvalid,
    input  logic               i_s_tready,
    input  logic [103:0]       i_s_tdata,  // client_pid, client_stream, units_wanted, pad
    input  logic [OP_W-1:0]    i_s_tuser,  // op
    input  logic               i_m_tvalid,
    input  logic               i_m_tready,
    input  logic [71:0]        i_m_tdata,  // disabled_units, live_entries, pad
    input  logic [2:0]         i_m_tuser,  // status, granted
    output int                 o_mismatches,
    output int                 o_waiting
);

    localparam int SLOTS = 64;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                granted;
        logic [MASK_W-1:0]   disabled;
        logic [LIVE_W-1:0]   live;
    } reply_t;

    logic                slot_live   [SLOTS];
    logic [PID_W-1:0]    slot_pid    [SLOTS];
    logic [STREAM_W-1:0] slot_stream [SLOTS];
    logic [MASK_W-1:0]   slot_mask   [SLOTS];
    logic [UNITS_W-1:0]  cursor     = '0;
    logic [UNITS_W-1:0]  unit_count = 7'd64;
    reply_t              replies_due [$];
    int                  mismatches = 0;
    int                  due_count  = 0;

    assign o_mismatches = mismatches;
    assign o_waiting    = due_count;

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            slot_live[i] = 1'b0;
        end
    end

    // Lowest-numbered live slot holding the key, or -1.
    function automatic int find_key(input logic [PID_W-1:0] pid,
                                    input logic [STREAM_W-1:0] stream);
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_live[i] && slot_pid[i] == pid && slot_stream[i] == stream) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic logic [LIVE_W-1:0] live_count();
        int n;
        n = 0;
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_live[i]) begin
                n++;
            end
        end
        return (n > int'(LIVE_MAX)) ? LIVE_MAX : LIVE_W'(n);
    endfunction

    // Applies one request to the table copy and returns the reply it should produce.
    function automatic reply_t serve_request(input t_op op,
                                             input logic [PID_W-1:0] pid,
                                             input logic [STREAM_W-1:0] stream,
                                             input logic [UNITS_W-1:0] want);
        reply_t            rep;
        int                hit;
        int                slot;
        logic [MASK_W-1:0] span;
        logic [MASK_W-1:0] grant;
        rep        = '0;
        rep.status = ST_OK;
        case (op)
            OP_ALLOC: begin
                if (want != '0) begin
                    hit = find_key(pid, stream);
                    if (hit >= 0) begin
                        rep.granted  = 1'b1;
                        rep.disabled = slot_mask[hit];
                    end else if (want <= unit_count &&
                                 int'(cursor) + int'(want) <= int'(unit_count)) begin
                        slot = -1;
                        for (int i = SLOTS - 1; i >= 0; i--) begin
                            if (!slot_live[i]) begin
                                slot = i;
                            end
                        end
                        if (slot < 0) begin
                            rep.status = ST_NO_SPACE;
                        end else begin
                            if (unit_count >= 7'd64) begin
                                span = '1;
                            end else if (unit_count == '0) begin
                                span = '0;
                            end else begin
                                span = (64'd1 << unit_count) - 64'd1;
                            end
                            if (want >= 7'd64) begin
                                grant = '1;
                            end else if (cursor >= 7'd64) begin
                                grant = '0;
                            end else begin
                                grant = ((64'd1 << want) - 64'd1) << cursor;
                            end
                            grant             = grant & span;
                            slot_live[slot]   = 1'b1;
                            slot_pid[slot]    = pid;
                            slot_stream[slot] = stream;
                            slot_mask[slot]   = ~grant & span;
                            cursor            = cursor + want;
                            rep.granted       = 1'b1;
                            rep.disabled      = slot_mask[slot];
                        end
                    end
                end
            end
            OP_FREE: begin
                hit = find_key(pid, stream);
                if (hit >= 0) begin
                    slot_live[hit] = 1'b0;
                end
                rep.live = live_count();
            end
            OP_STATS: begin
                rep.live = live_count();
            end
            default: begin
                rep.status = ST_BAD_OP;
            end
        endcase
        return rep;
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] expected,
                                 input logic [63:0] actual);
        mismatches++;
        $display("%0t: %s expected %0h, got %0h", $time, what, expected, actual);
    endtask

    always @(posedge i_clk) begin
        reply_t got;
        reply_t due;
        if (i_rst_n) begin
            if (i_m_tvalid && i_m_tready) begin
                got = {i_m_tuser[1:0], i_m_tuser[2], i_m_tdata[63:0], i_m_tdata[70:64]};
                if (replies_due.size() == 0) begin
                    mismatches++;
                    $display({"%0t: result expected none, got status %0d granted %0b",
                              " mask %h live %0d"},
                             $time, got.status, got.granted, got.disabled, got.live);
                end else begin
                    due = replies_due.pop_front();
                    if (got.status !== due.status) begin
                        note_mismatch("status", 64'(due.status), 64'(got.status));
                    end
                    if (got.granted !== due.granted) begin
                        note_mismatch("granted", 64'(due.granted), 64'(got.granted));
                    end
                    if (got.disabled !== due.disabled) begin
                        note_mismatch("disabled_units", due.disabled, got.disabled);
                    end
                    if (got.live !== due.live) begin
                        note_mismatch("live_entries", 64'(due.live), 64'(got.live));
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                unit_count = i_cfg_data;
            end
            if (i_s_tvalid && i_s_tready) begin
                replies_due.push_back(serve_request(t_op'(i_s_tuser), i_s_tdata[63:0],
                                                    i_s_tdata[95:64], i_s_tdata[102:96]));
            end
            due_count = replies_due.size();
        end
    end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// Top of the allocator testbench: clock, reset, request stimulus and the final verdict.
module testbench;
    import pbalc_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int KEY_POOL     = 96;
    localparam int FILL_ITEMS   = 61;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 134;
    localparam int DRAIN_CYCLES = 80;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [UNITS_W-1:0] cfg_data  = '0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [103:0]       s_tdata   = '0;  // client_pid, client_stream, units_wanted, pad
    logic [OP_W-1:0]    s_tuser   = '0;  // op
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [71:0]        m_tdata;         // disabled_units, live_entries, pad
    logic [2:0]         m_tuser;         // status, granted

    int   fail_count;
    int   waiting;
    int   cycle_count = 0;
    logic send_gaps   = 1'b1;
    logic take_gaps   = 1'b1;

    logic [PID_W-1:0]    pool_pid    [KEY_POOL];
    logic [STREAM_W-1:0] pool_stream [KEY_POOL];

    partition_bump_allocator #(
        .TABLE_ENTRIES(64)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    allocator_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tuser   (m_tuser),
        .o_mismatches(fail_count),
        .o_waiting   (waiting)
    );

    always #(CLK_HALF) clk = ~clk;

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    always @(negedge clk) begin
        m_tready <= !take_gaps || ($urandom_range(99) >= 23);
    end

    // Called just after a falling edge; returns just after the falling edge that follows
    // the transfer, with tvalid still high so that the next request can follow directly.
    task automatic send_request(input t_op op, input logic [PID_W-1:0] pid,
                                input logic [STREAM_W-1:0] stream,
                                input logic [UNITS_W-1:0] want);
        if (send_gaps && $urandom_range(99) < 23) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 90)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, want, stream, pid};
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
    endtask

    // The unit count is only changed once every outstanding result has been taken.
    task automatic write_unit_count(input logic [UNITS_W-1:0] value);
        s_tvalid <= 1'b0;
        while (waiting != 0) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_request();
        int unsigned         pick;
        int unsigned         roll;
        logic [PID_W-1:0]    pid;
        logic [STREAM_W-1:0] stream;
        logic [UNITS_W-1:0]  want;
        t_op                 op;
        pick   = $urandom_range(KEY_POOL - 1);
        pid    = pool_pid[pick];
        stream = pool_stream[pick];
        if ($urandom_range(19) == 0) begin
            pid    = {$urandom, $urandom};
            stream = $urandom;
        end
        want = 7'($urandom_range(64));
        roll = $urandom_range(99);
        if (roll < 45) begin
            op = OP_ALLOC;
            // Small quotas keep the few units left behind the cursor usable.
            case ($urandom_range(9))
                0:             want = '0;
                1, 2, 3, 4, 5: want = 7'd1;
                6, 7:          want = 7'd2;
                default:       ;
            endcase
        end else if (roll < 75) begin
            op = OP_FREE;
        end else if (roll < 93) begin
            op = OP_STATS;
        end else begin
            op = OP_INVALID;
        end
        send_request(op, pid, stream, want);
    endtask

    initial begin
        logic [PID_W-1:0]    pid_c;
        logic [PID_W-1:0]    pid_d;
        logic [STREAM_W-1:0] stream_c;
        logic [STREAM_W-1:0] stream_d;
        logic [UNITS_W-1:0]  setting;

        // Neighbouring pool keys sometimes share one half of the key.
        for (int i = 0; i < KEY_POOL; i++) begin
            pool_pid[i]    = (i % 4 == 1) ? pool_pid[i - 1] : {$urandom, $urandom};
            pool_stream[i] = (i % 4 == 2) ? pool_stream[i - 1] : $urandom;
        end
        pid_c    = {$urandom, $urandom};
        pid_d    = {$urandom, $urandom};
        stream_c = $urandom;
        stream_d = $urandom;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, starting from the reset unit count of 64.
        send_request(OP_STATS, '0, '0, '0);
        send_request(OP_INVALID, '1, '1, 7'd64);
        send_request(OP_ALLOC, '1, '1, '0);
        send_request(OP_FREE, {$urandom, $urandom}, $urandom, '0);
        send_request(OP_ALLOC, '1, '1, 7'd1);
        send_request(OP_ALLOC, '1, '1, 7'd7);
        send_request(OP_ALLOC, '0, '0, 7'd64);
        send_request(OP_FREE, '1, '1, '0);
        send_request(OP_ALLOC, '0, '0, 7'd2);
        // With no units at all a known key still gets its stored mask back.
        write_unit_count(7'd0);
        send_request(OP_ALLOC, '0, '0, 7'd1);
        send_request(OP_ALLOC, pid_c, stream_c, 7'd1);
        write_unit_count(7'd8);
        send_request(OP_ALLOC, pid_c, stream_c, 7'd9);
        send_request(OP_ALLOC, pid_c, stream_c, 7'd5);
        send_request(OP_ALLOC, pid_d, stream_d, 7'd1);
        // The widest count leaves the cursor at unit 64, past the end of the mask.
        write_unit_count(7'd127);
        send_request(OP_ALLOC, pid_d, stream_d, 7'd56);
        send_request(OP_STATS, '0, '0, '0);

        // Fill every slot with one-unit grants, then ask for more while units remain.
        for (int i = 0; i < FILL_ITEMS; i++) begin
            send_request(OP_ALLOC, pool_pid[i], pool_stream[i], 7'd1);
        end
        send_request(OP_ALLOC, pool_pid[FILL_ITEMS], pool_stream[FILL_ITEMS], 7'd1);
        send_request(OP_ALLOC, pool_pid[FILL_ITEMS], pool_stream[FILL_ITEMS], 7'd2);
        send_request(OP_ALLOC, pool_pid[FILL_ITEMS], pool_stream[FILL_ITEMS], 7'd3);

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       setting = 7'd127;
                1:       setting = 7'd1;
                2:       setting = 7'd64;
                3:       setting = 7'd0;
                4:       setting = 7'd126;
                6:       setting = 7'd127;
                default: setting = 7'($urandom_range(1, 127));
            endcase
            write_unit_count(setting);
            // One whole phase runs with neither side idling.
            send_gaps = (phase != 2);
            take_gaps <= (phase != 2);
            repeat (PHASE_ITEMS) random_request();
        end

        s_tvalid <= 1'b0;
        while (waiting != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
